// File: rtl/dca_pkg.sv
package dca_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = 4;
    localparam int CNT_W = 5;
    localparam int MODULES = 8;
    localparam logic [7:0] DEFAULT_PRIORITY = 8'd128;

    localparam logic [1:0] MODE_STRONGEST = 2'd0;
    localparam logic [1:0] MODE_PRIORITY = 2'd1;
    localparam logic [1:0] MODE_ROUND_ROBIN = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_IGNITION = 3'd1;
    localparam logic [2:0] REG_DECAY_RATE = 3'd2;
    localparam logic [2:0] REG_KEEP = 3'd3;
    localparam logic [2:0] REG_PRIORITY = 3'd4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] ignition_level;
        logic [15:0] decay_rate;
        logic [15:0] keep_level;
        logic [63:0] priority_table;
    } cfg_t;

    function automatic logic [16:0] exp_entry(input logic [7:0] idx);
        logic [63:0] q;
        logic [16:0] r;
        q = 64'd1 << 32;
        r = 17'd0;
        for (int i = 0; i < 256; i++) begin
            if (i == int'(idx)) begin
                r = 17'((q + 64'd32768) >> 16);
            end
            q = (q * 64'd4162825044 + (64'd1 << 31)) >> 32;
        end
        return r;
    endfunction

    function automatic logic [7:0] priority_of(input logic [63:0] tab, input logic [3:0] m);
        logic [7:0] p;
        p = DEFAULT_PRIORITY;
        if (int'(m) < MODULES && m < 4'd8) begin
            p = tab[8*m[2:0] +: 8];
        end
        return p;
    endfunction

endpackage

// File: rtl/decaying_competition_arbiter.sv
// Decaying competition arbiter.
// Input channel s_axis: one transaction per write or resolve item; tdata holds,
// from bit 0 up, operation, slot, set_active, entry_strength, entry_module, time_ms.
// Result channel m_axis: exactly one transaction per input item; tdata holds,
// from bit 0 up, found, winner slot, winner's decayed strength, runner-up raw
// strength, broadcast number, active count.
// Configuration: cfg_we with cfg_index 0..4 (mode, ignition, decay rate, keep
// level, module priority table); write only while idle.
// A write item goes from acceptance straight to S_OUT, which registers its result;
// the next item is taken only after that result has left m_axis.
// A resolve walks all 16 slots through the decay unit, one register stage deep,
// then makes a selection pass and a runner-up pass over the 16 slots each; S_OUT
// registers its result, and the next item is taken only after that result has left.
// s_axis_tready is low while an item is in work or its result is held.
// A stalled m_axis holds its result; the block takes nothing new meanwhile.
// Reset clears slot flags, counters, last winner and configuration to defaults.
module decaying_competition_arbiter (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // op, slot[4], set, strength[16], module[4], time[32]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,  // found, slot[4], strength[16], runner[16], bnum[32], count[5]
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_DECAY, S_SELECT, S_RUNNER, S_OUT} state_t;
    state_t state_reg;

    dca_pkg::cfg_t cfg_reg;
    logic [dca_pkg::SLOTS-1:0] act_reg;
    logic [15:0] str_mem [dca_pkg::SLOTS];
    logic [31:0] time_mem [dca_pkg::SLOTS];
    logic [3:0]  mod_mem [dca_pkg::SLOTS];
    logic [15:0] dec_mem [dca_pkg::SLOTS];
    logic [dca_pkg::CNT_W-1:0] live_reg;
    logic [3:0]  last_reg;
    logic [31:0] bcast_reg;
    logic [31:0] now_reg;
    logic [4:0]  idx_reg;
    logic [3:0]  sidx;
    logic [15:0] dec_out;
    logic        any_reg, found_reg;
    logic [3:0]  w_reg;
    logic [8:0]  bp_reg;
    logic [15:0] bs_reg, run_reg;
    logic [3:0]  rr_idx;
    logic [8:0]  p9;
    logic [3:0]  wi;

    assign sidx = idx_reg[3:0];

    dca_decay u_decay (
        .aclk(aclk), .strength(str_mem[sidx]), .stamp(time_mem[sidx]),
        .now(now_reg), .decay_rate(cfg_reg.decay_rate), .decayed(dec_out)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !m_axis_tvalid;
    assign rr_idx = last_reg + 4'd1 + sidx;
    assign p9 = {1'b0, dca_pkg::priority_of(cfg_reg.priority_table, mod_mem[sidx])};
    assign wi = s_axis_tdata[4:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cfg_reg <= '{dca_pkg::MODE_STRONGEST, 16'd32768, 16'd0, 16'd6554, 64'd0};
            act_reg <= '0;
            live_reg <= '0;
            last_reg <= '0;
            bcast_reg <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    dca_pkg::REG_MODE:       cfg_reg.mode <= cfg_data[1:0];
                    dca_pkg::REG_IGNITION:   cfg_reg.ignition_level <= cfg_data[15:0];
                    dca_pkg::REG_DECAY_RATE: cfg_reg.decay_rate <= cfg_data[15:0];
                    dca_pkg::REG_KEEP:       cfg_reg.keep_level <= cfg_data[15:0];
                    dca_pkg::REG_PRIORITY:   cfg_reg.priority_table <= cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    now_reg <= s_axis_tdata[57:26];
                    idx_reg <= '0;
                    any_reg <= 1'b0; found_reg <= 1'b0;
                    w_reg <= '0; bp_reg <= '0; bs_reg <= '0; run_reg <= '0;
                    if (s_axis_tdata[0] == dca_pkg::OP_WRITE) begin
                        if (s_axis_tdata[5]) begin
                            if (!act_reg[wi]) live_reg <= live_reg + 5'd1;
                            act_reg[wi] <= 1'b1;
                            str_mem[wi] <= s_axis_tdata[21:6];
                            mod_mem[wi] <= s_axis_tdata[25:22];
                            time_mem[wi] <= s_axis_tdata[57:26];
                        end else if (act_reg[wi]) begin
                            act_reg[wi] <= 1'b0;
                            live_reg <= live_reg - 5'd1;
                        end
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_DECAY;
                    end
                end
                S_DECAY: begin
                    // decay unit registers its inputs: result for idx-1 now present
                    if (idx_reg != 5'd0) begin
                        dec_mem[4'(idx_reg - 5'd1)] <= dec_out;
                        if (act_reg[4'(idx_reg - 5'd1)] && dec_out < cfg_reg.keep_level) begin
                            act_reg[4'(idx_reg - 5'd1)] <= 1'b0;
                            live_reg <= live_reg - 5'd1;
                        end
                    end
                    if (idx_reg == 5'd16) begin
                        idx_reg <= '0; state_reg <= S_SELECT;
                    end else idx_reg <= idx_reg + 5'd1;
                end
                S_SELECT: begin
                    unique case (cfg_reg.mode)
                        dca_pkg::MODE_STRONGEST:
                            if (act_reg[sidx] && dec_mem[sidx] > bs_reg) begin
                                bs_reg <= dec_mem[sidx]; w_reg <= sidx; any_reg <= 1'b1;
                            end
                        dca_pkg::MODE_PRIORITY:
                            if (act_reg[sidx] && (!any_reg || p9 > bp_reg ||
                                (p9 == bp_reg && dec_mem[sidx] > bs_reg))) begin
                                bp_reg <= p9; bs_reg <= dec_mem[sidx];
                                w_reg <= sidx; any_reg <= 1'b1;
                            end
                        dca_pkg::MODE_ROUND_ROBIN:
                            if (!any_reg && act_reg[rr_idx]) begin
                                w_reg <= rr_idx; any_reg <= 1'b1;
                            end
                        default: ;
                    endcase
                    if (idx_reg == 5'd15) begin
                        idx_reg <= '0; state_reg <= S_RUNNER;
                    end else idx_reg <= idx_reg + 5'd1;
                end
                S_RUNNER: begin
                    if (idx_reg == 5'd0) begin
                        found_reg <= any_reg && ((cfg_reg.mode == dca_pkg::MODE_ROUND_ROBIN) ||
                                     bs_reg >= cfg_reg.ignition_level);
                        if (any_reg && cfg_reg.mode == dca_pkg::MODE_ROUND_ROBIN)
                            last_reg <= w_reg;
                        bs_reg <= dec_mem[w_reg];
                    end
                    if (sidx != w_reg && act_reg[sidx] && str_mem[sidx] > run_reg)
                        run_reg <= str_mem[sidx];
                    if (idx_reg == 5'd15) state_reg <= S_OUT;
                    else idx_reg <= idx_reg + 5'd1;
                end
                S_OUT: begin
                    m_axis_tvalid <= 1'b1;
                    if (found_reg) begin
                        m_axis_tdata <= {6'd0, live_reg, bcast_reg, run_reg, bs_reg,
                                         w_reg, 1'b1};
                        bcast_reg <= bcast_reg + 32'd1;
                    end else begin
                        m_axis_tdata <= {6'd0, live_reg, 69'd0};
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> live_reg == 5'($countones(act_reg)))
        else $error("live count mismatch");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> state_reg == S_IDLE)
        else $error("ready while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
endmodule

// File: rtl/dca_decay.sv
module dca_decay (
    input  logic        aclk,
    input  logic [15:0] strength,
    input  logic [31:0] stamp,
    input  logic [31:0] now,
    input  logic [15:0] decay_rate,
    output logic [15:0] decayed
);
    logic [47:0] x_reg;
    logic [15:0] s_reg;
    logic [16:0] f;
    logic [32:0] prod;

    always_ff @(posedge aclk) begin
        x_reg <= 48'(now - stamp) * 48'(decay_rate);
        s_reg <= strength;
    end

    assign f = dca_pkg::exp_entry(x_reg[18:11]);
    assign prod = 33'(s_reg) * 33'(f);
    assign decayed = (x_reg >= (48'd8 << 16)) ? 16'd0 : prod[31:16];
endmodule

// File: tb/decaying_competition_arbiter_test.sv
`timescale 1ns / 100ps

module decaying_competition_arbiter_test;

    typedef struct {
        logic        op;
        logic [3:0]  slot;
        logic        set;
        logic [15:0] strength;
        logic [3:0]  modl;
        logic [31:0] now_ms;
    } req_t;

    typedef struct {
        logic        found;
        logic [3:0]  slot;
        logic [15:0] wstr;
        logic [15:0] runner;
        logic [31:0] bnum;
        logic [4:0]  count;
    } verdict_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // op, slot[4], set, strength[16], module[4], time[32]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // found, slot[4], wstr[16], runner[16], bnum[32], count[5]
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    decaying_competition_arbiter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // arbiter mirror
    logic [16:0] decay_tab [256];
    logic [1:0]  arb_mode;
    logic [15:0] arb_ignition;
    logic [15:0] arb_rate;
    logic [15:0] arb_keep;
    logic [63:0] arb_prio;
    logic        slot_live [dca_pkg::SLOTS];
    logic [15:0] slot_str [dca_pkg::SLOTS];
    logic [31:0] slot_stamp [dca_pkg::SLOTS];
    logic [3:0]  slot_mod [dca_pkg::SLOTS];
    logic [4:0]  live_total;
    logic [3:0]  last_win;
    logic [31:0] next_bnum;

    verdict_t    verdicts [$];
    int          errors;
    int          cycles;
    int          ready_hold;
    bit          idling;
    logic [31:0] clock_ms;

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("decaying_competition_arbiter_test NOT OK");
            $finish;
        end
    end

    function automatic logic [15:0] decayed(input logic [15:0] s, input logic [31:0] stamp,
                                            input logic [31:0] now_ms);
        logic [31:0] age;
        logic [47:0] x;
        logic [32:0] prod;
        age = now_ms - stamp;
        x = 48'(age) * 48'(arb_rate);
        if (x >= (48'd8 << 16)) return 16'd0;
        prod = 33'(s) * 33'(decay_tab[x[18:11]]);
        return prod[31:16];
    endfunction

    function automatic int prio(input logic [3:0] m);
        if (m < 4'd8) return int'(arb_prio[8*m[2:0] +: 8]);
        return 128;
    endfunction

    function automatic verdict_t arbitrate(input req_t r);
        verdict_t v;
        logic [15:0] dec [dca_pkg::SLOTS];
        logic [15:0] best;
        int bestp;
        int p;
        int idx;
        v = '{1'b0, 4'd0, 16'd0, 16'd0, 32'd0, 5'd0};
        if (r.op == dca_pkg::OP_WRITE) begin
            if (r.set) begin
                if (!slot_live[r.slot]) live_total++;
                slot_live[r.slot] = 1'b1;
                slot_str[r.slot] = r.strength;
                slot_mod[r.slot] = r.modl;
                slot_stamp[r.slot] = r.now_ms;
            end else if (slot_live[r.slot]) begin
                slot_live[r.slot] = 1'b0;
                live_total--;
            end
        end else begin
            for (int i = 0; i < dca_pkg::SLOTS; i++) begin
                dec[i] = 16'd0;
                if (slot_live[i]) begin
                    dec[i] = decayed(slot_str[i], slot_stamp[i], r.now_ms);
                    if (dec[i] < arb_keep) begin
                        slot_live[i] = 1'b0;
                        live_total--;
                    end
                end
            end
            best = 16'd0;
            bestp = -1;
            case (arb_mode)
                dca_pkg::MODE_STRONGEST: begin
                    for (int i = 0; i < dca_pkg::SLOTS; i++) begin
                        if (slot_live[i] && dec[i] > best) begin
                            best = dec[i];
                            v.slot = 4'(i);
                            v.found = 1'b1;
                        end
                    end
                    v.found = v.found && best >= arb_ignition;
                end
                dca_pkg::MODE_PRIORITY: begin
                    for (int i = 0; i < dca_pkg::SLOTS; i++) begin
                        if (slot_live[i]) begin
                            p = prio(slot_mod[i]);
                            if (p > bestp || (p == bestp && dec[i] > best)) begin
                                bestp = p;
                                best = dec[i];
                                v.slot = 4'(i);
                                v.found = 1'b1;
                            end
                        end
                    end
                    v.found = v.found && best >= arb_ignition;
                end
                dca_pkg::MODE_ROUND_ROBIN: begin
                    for (int off = 1; off <= dca_pkg::SLOTS; off++) begin
                        idx = (int'(last_win) + off) % dca_pkg::SLOTS;
                        if (!v.found && slot_live[idx]) begin
                            v.found = 1'b1;
                            v.slot = 4'(idx);
                            last_win = 4'(idx);
                        end
                    end
                end
                default: ;
            endcase
            if (v.found) begin
                v.wstr = dec[v.slot];
                for (int i = 0; i < dca_pkg::SLOTS; i++) begin
                    if (i != int'(v.slot) && slot_live[i] && slot_str[i] > v.runner)
                        v.runner = slot_str[i];
                end
                v.bnum = next_bnum;
                next_bnum++;
            end else begin
                v.slot = 4'd0;
            end
        end
        v.count = live_total;
        return v;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge aclk) begin
        verdict_t w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (verdicts.size() == 0) begin
                report("unexpected transaction", 32'(m_axis_tdata[4:0]), 32'd0);
            end else begin
                w = verdicts.pop_front();
                if (m_axis_tdata[0] !== w.found)
                    report("found", 32'(m_axis_tdata[0]), 32'(w.found));
                if (m_axis_tdata[4:1] !== w.slot)
                    report("winner slot", 32'(m_axis_tdata[4:1]), 32'(w.slot));
                if (m_axis_tdata[20:5] !== w.wstr)
                    report("win level", 32'(m_axis_tdata[20:5]), 32'(w.wstr));
                if (m_axis_tdata[36:21] !== w.runner)
                    report("second level", 32'(m_axis_tdata[36:21]), 32'(w.runner));
                if (m_axis_tdata[68:37] !== w.bnum)
                    report("broadcast number", m_axis_tdata[68:37], w.bnum);
                if (m_axis_tdata[73:69] !== w.count)
                    report("active count", 32'(m_axis_tdata[73:69]), 32'(w.count));
            end
            ready_hold = idling ? $urandom_range(0, 5) : 0;
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_hold > 0) begin
                m_axis_tready <= 1'b0;
                ready_hold--;
            end else begin
                m_axis_tready <= aresetn;
            end
        end
    end

    task automatic send(input req_t r);
        int gap;
        gap = idling ? $urandom_range(0, 5) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata <= {6'd0, r.now_ms, r.modl, r.strength, r.set, r.slot, r.op};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        verdicts.push_back(arbitrate(r));
    endtask

    task automatic slot_write(input int s, input bit set, input logic [15:0] st,
                              input logic [3:0] m, input logic [31:0] t);
        send('{dca_pkg::OP_WRITE, 4'(s), set, st, m, t});
    endtask

    task automatic resolve(input logic [31:0] t);
        send('{dca_pkg::OP_RESOLVE, 4'($urandom), 1'($urandom), 16'($urandom),
               4'($urandom), t});
    endtask

    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (verdicts.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    task automatic configure(input logic [1:0] md, input logic [15:0] ign, input logic [15:0] rate,
                             input logic [15:0] keep, input logic [63:0] tab);
        drain();
        cfg_write(dca_pkg::REG_MODE, 64'(md));
        cfg_write(dca_pkg::REG_IGNITION, 64'(ign));
        cfg_write(dca_pkg::REG_DECAY_RATE, 64'(rate));
        cfg_write(dca_pkg::REG_KEEP, 64'(keep));
        cfg_write(dca_pkg::REG_PRIORITY, tab);
        @(negedge aclk);
        cfg_we <= 1'b0;
        arb_mode = md;
        arb_ignition = ign;
        arb_rate = rate;
        arb_keep = keep;
        arb_prio = tab;
    endtask

    task automatic test_directed();
        resolve(32'd0);
        slot_write(0, 1, 16'hFFFF, 4'd15, 32'hFFFF_FFFF);
        slot_write(15, 1, 16'd40000, 4'd8, 32'd0);
        slot_write(3, 1, 16'd100, 4'd2, 32'd0);
        slot_write(3, 0, 16'd0, 4'd0, 32'd0);
        slot_write(3, 0, 16'hFFFF, 4'd1, 32'd0);
        slot_write(0, 1, 16'hFFFE, 4'd0, 32'd7);
        slot_write(5, 1, 16'd20000, 4'd7, 32'd9);
        resolve(32'd0);
        configure(dca_pkg::MODE_PRIORITY, 16'd0, 16'd0, 16'd0, 64'hFF00_0000_0000_0001);
        resolve(32'd100);
        configure(dca_pkg::MODE_ROUND_ROBIN, 16'hFFFF, 16'd0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        repeat (4) resolve(32'd200);
        configure(dca_pkg::MODE_NONE, 16'd0, 16'd0, 16'd0, 64'd0);
        resolve(32'd300);
        configure(dca_pkg::MODE_STRONGEST, 16'd0, 16'hFFFF, 16'd0, 64'd0);
        slot_write(1, 1, 16'hFFFF, 4'd3, 32'd10);
        resolve(32'd10);
        resolve(32'd11);
        resolve(32'd20);
        resolve(32'd5);
        configure(dca_pkg::MODE_STRONGEST, 16'd0, 16'd0, 16'hFFFF, 64'd0);
        resolve(32'd5);
    endtask

    task automatic test_random(input int items);
        req_t r;
        for (int n = 0; n < items; n++) begin
            clock_ms += $urandom_range(0, 40);
            r.op = ($urandom_range(0, 9) < 4) ? dca_pkg::OP_RESOLVE : dca_pkg::OP_WRITE;
            r.slot = 4'($urandom);
            r.set = ($urandom_range(0, 4) != 0);
            r.strength = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
            r.modl = 4'($urandom);
            r.now_ms = (r.op == dca_pkg::OP_RESOLVE) ? clock_ms + $urandom_range(0, 300)
                                                     : clock_ms;
            if ($urandom_range(0, 15) == 0) r.now_ms = $urandom;
            send(r);
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        ready_hold = 0;
        idling = 1'b1;
        clock_ms = 32'd1000;
        begin
            logic [63:0] q;
            q = 64'd1 << 32;
            for (int i = 0; i < 256; i++) begin
                decay_tab[i] = 17'((q + 64'd32768) >> 16);
                q = (q * 64'd4162825044 + (64'd1 << 31)) >> 32;
            end
        end
        arb_mode = dca_pkg::MODE_STRONGEST;
        arb_ignition = 16'd32768;
        arb_rate = 16'd0;
        arb_keep = 16'd6554;
        arb_prio = 64'd0;
        for (int i = 0; i < dca_pkg::SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_str[i] = 16'd0;
            slot_stamp[i] = 32'd0;
            slot_mod[i] = 4'd0;
        end
        live_total = 5'd0;
        last_win = 4'd0;
        next_bnum = 32'd0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        configure(dca_pkg::MODE_STRONGEST, 16'd30000, 16'd300, 16'd6554,
                  64'h0102_0304_0506_0708);
        test_random(100);
        configure(dca_pkg::MODE_PRIORITY, 16'd20000, 16'd2000, 16'd1000,
                  64'($urandom) << 32 | $urandom);
        idling = 1'b0;
        test_random(100);
        idling = 1'b1;
        configure(dca_pkg::MODE_ROUND_ROBIN, 16'hFFFF, 16'd100, 16'd0, 64'd0);
        test_random(100);
        configure(dca_pkg::MODE_STRONGEST, 16'd0, 16'hFFFF, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        test_random(80);
        configure(dca_pkg::MODE_PRIORITY, 16'hFFFF, 16'd0, 16'hFFFF, 64'h8080_8080_8080_8080);
        test_random(60);
        configure(dca_pkg::MODE_PRIORITY, 16'd0, 16'd50, 16'd0,
                  64'($urandom) << 32 | $urandom);
        test_random(100);
        configure(dca_pkg::MODE_NONE, 16'd100, 16'd500, 16'd3000, 64'd0);
        test_random(40);
        drain();

        if (errors == 0) begin
            $display("decaying_competition_arbiter_test OK");
        end else begin
            $display("decaying_competition_arbiter_test NOT OK");
        end
        $finish;
    end

endmodule

// File: decaying_competition_arbiter.f
rtl/dca_pkg.sv
rtl/dca_decay.sv
rtl/decaying_competition_arbiter.sv
tb/decaying_competition_arbiter_test.sv
